// ===== rtl/ipip_dsr_backend_select_encap_top_macros.svh =====
// ----------------------------------------------------------------------------
// IPIP DSR backend selector assertion macros
// Shared assertion forms for the backend selector's own checks.
// ----------------------------------------------------------------------------
`ifndef IPIP_DSR_BACKEND_SELECT_ENCAP_TOP_MACROS_SVH
`define IPIP_DSR_BACKEND_SELECT_ENCAP_TOP_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define IPDSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define IPDSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ipdsr_pkg.sv =====
// ----------------------------------------------------------------------------
// IPIP DSR backend selector package
// Types, register codes and constants shared by the selector's modules.
// ----------------------------------------------------------------------------
package ipdsr_pkg;

	localparam int BACKEND_COUNT = 2;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_IPIP = 8'd4;
	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [7:0] OUTER_TTL = 8'd64;
	localparam logic [15:0] OUTER_HDR_LEN = 16'd20;
	localparam logic [15:0] OUTER_VER_IHL = 16'h4500;
	localparam logic [15:0] DEFAULT_SERVICE_PORT = 16'd8000;

	localparam int PADDR_WIDTH = 4;

	typedef enum logic [1:0] {
		REG_BACKEND_IP_0 = 2'd0,
		REG_BACKEND_IP_1 = 2'd1,
		REG_BALANCER_IP = 2'd2,
		REG_SERVICE_PORT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] backend_ip_0;
		logic [31:0] backend_ip_1;
		logic [31:0] balancer_ip;
		logic [15:0] service_port;
	} cfg_t;

	typedef struct packed {
		logic headers_complete;
		logic [15:0] ether_type;
		logic [7:0] ip_proto;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] tcp_sport;
		logic [15:0] tcp_dport;
		logic [15:0] ip_total_len;
	} in_item_t;

	typedef struct packed {
		logic forward;
		logic backend_index;
		logic [31:0] outer_src_ip;
		logic [31:0] outer_dst_ip;
		logic [15:0] outer_total_len;
		logic [15:0] outer_checksum;
		logic length_wrapped;
	} out_item_t;

	typedef struct packed {
		logic forward;
		logic [31:0] src_word;
		logic [31:0] dst_word;
		logic [15:0] sport_word;
		logic [15:0] dport_word;
		logic [15:0] encap_len;
		logic wrapped;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== rtl/ipdsr_cfg.sv =====
// ----------------------------------------------------------------------------
// IPIP DSR configuration registers
// APB-style register file holding backend, balancer and service port values.
// ----------------------------------------------------------------------------
module ipdsr_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ipdsr_pkg::PADDR_WIDTH-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output ipdsr_pkg::cfg_t cfg
);

	ipdsr_pkg::reg_idx_t idx;
	logic wr_en;
	ipdsr_pkg::cfg_t cfg_q;

	assign idx = ipdsr_pkg::reg_idx_t'(paddr[ipdsr_pkg::PADDR_WIDTH-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.backend_ip_0 <= '0;
			cfg_q.backend_ip_1 <= '0;
			cfg_q.balancer_ip <= '0;
			cfg_q.service_port <= ipdsr_pkg::DEFAULT_SERVICE_PORT;
		end else if (wr_en) begin
			case (idx)
				ipdsr_pkg::REG_BACKEND_IP_0: cfg_q.backend_ip_0 <= pwdata;
				ipdsr_pkg::REG_BACKEND_IP_1: cfg_q.backend_ip_1 <= pwdata;
				ipdsr_pkg::REG_BALANCER_IP: cfg_q.balancer_ip <= pwdata;
				ipdsr_pkg::REG_SERVICE_PORT: cfg_q.service_port <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			ipdsr_pkg::REG_BACKEND_IP_0: prdata = cfg_q.backend_ip_0;
			ipdsr_pkg::REG_BACKEND_IP_1: prdata = cfg_q.backend_ip_1;
			ipdsr_pkg::REG_BALANCER_IP: prdata = cfg_q.balancer_ip;
			ipdsr_pkg::REG_SERVICE_PORT: prdata = {16'd0, cfg_q.service_port};
			default: prdata = '0;
		endcase
	end

endmodule

// ===== rtl/ipdsr_front.sv =====
// ----------------------------------------------------------------------------
// IPIP DSR front end
// Accepts header words, classifies them and prepares the hash words.
// ----------------------------------------------------------------------------
module ipdsr_front (
	input  logic in_valid,
	output logic in_stall,
	input  ipdsr_pkg::in_item_t in_data,
	input  logic [15:0] service_port,
	input  ipdsr_pkg::q_status_t q_status,
	output logic push,
	output ipdsr_pkg::entry_t entry
);

	logic match;
	logic [16:0] len_sum;

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	assign match = in_data.headers_complete
		&& (in_data.ether_type == ipdsr_pkg::ETH_IPV4)
		&& (in_data.ip_proto == ipdsr_pkg::PROTO_TCP)
		&& ((in_data.tcp_sport == service_port) || (in_data.tcp_dport == service_port));

	assign len_sum = {1'b0, in_data.ip_total_len} + {1'b0, ipdsr_pkg::OUTER_HDR_LEN};

	assign in_stall = q_status.full;
	assign push = in_valid && !q_status.full;

	always_comb begin
		entry.forward = match;
		entry.src_word = swap32(in_data.src_ip);
		entry.dst_word = swap32(in_data.dst_ip);
		entry.sport_word = swap16(in_data.tcp_sport);
		entry.dport_word = swap16(in_data.tcp_dport);
		entry.encap_len = len_sum[15:0];
		entry.wrapped = len_sum[16];
	end

endmodule

// ===== rtl/ipdsr_queue.sv =====
// ----------------------------------------------------------------------------
// IPIP DSR decoupling queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ipdsr_queue #(
	parameter int DEPTH = ipdsr_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ipdsr_pkg::entry_t wr_entry,
	input  logic pop,
	output ipdsr_pkg::entry_t rd_entry,
	output ipdsr_pkg::q_status_t status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ipdsr_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign status.full = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/ipdsr_back.sv =====
// ----------------------------------------------------------------------------
// IPIP DSR back end
// Five-stage FNV-1a hash pipeline, backend pick and outer header build.
// ----------------------------------------------------------------------------
module ipdsr_back #(
	parameter int BACKEND_COUNT = ipdsr_pkg::BACKEND_COUNT
) (
	input  logic clk,
	input  logic arst_n,
	input  ipdsr_pkg::cfg_t cfg,
	input  ipdsr_pkg::q_status_t q_status,
	input  ipdsr_pkg::entry_t q_entry,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output ipdsr_pkg::out_item_t out_data
);

	localparam int Stages = 5;

	logic adv;
	logic vld_s [Stages];
	logic [31:0] hash_s [Stages];
	ipdsr_pkg::entry_t ent_s [Stages];
	logic out_valid_q;
	ipdsr_pkg::out_item_t out_q;
	ipdsr_pkg::out_item_t result;

	function automatic logic [31:0] hash_word(input ipdsr_pkg::entry_t e, input int k);
		logic [31:0] w;
		case (k)
			0: w = e.src_word;
			1: w = e.dst_word;
			2: w = {16'd0, e.sport_word};
			3: w = {16'd0, e.dport_word};
			default: w = {24'd0, ipdsr_pkg::PROTO_TCP};
		endcase
		return w;
	endfunction

	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [31:0] w);
		return (h ^ w) * ipdsr_pkg::FNV_PRIME;
	endfunction

	function automatic logic [15:0] hdr_checksum(input logic [15:0] len,
		input logic [31:0] src, input logic [31:0] dst);
		logic [18:0] sum;
		logic [16:0] fold1;
		logic [15:0] fold2;
		sum = 19'(ipdsr_pkg::OUTER_VER_IHL) + 19'(len)
			+ 19'({ipdsr_pkg::OUTER_TTL, ipdsr_pkg::PROTO_IPIP})
			+ 19'(src[31:16]) + 19'(src[15:0]) + 19'(dst[31:16]) + 19'(dst[15:0]);
		fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
		fold2 = fold1[15:0] + 16'(fold1[16]);
		return ~fold2;
	endfunction

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && !q_status.empty;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < Stages; k++) begin
				vld_s[k] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= !q_status.empty;
			for (int k = 1; k < Stages; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			out_valid_q <= vld_s[Stages-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s[0] <= q_entry;
			hash_s[0] <= fnv_step(ipdsr_pkg::FNV_OFFSET, hash_word(q_entry, 0));
			for (int k = 1; k < Stages; k++) begin
				ent_s[k] <= ent_s[k-1];
				hash_s[k] <= fnv_step(hash_s[k-1], hash_word(ent_s[k-1], k));
			end
			out_q <= result;
		end
	end

	always_comb begin
		logic idx;
		logic [31:0] bip;
		idx = (BACKEND_COUNT == 2) ? hash_s[Stages-1][0] : 1'b0;
		bip = idx ? cfg.backend_ip_1 : cfg.backend_ip_0;
		result = '0;
		if (ent_s[Stages-1].forward) begin
			result.forward = 1'b1;
			result.backend_index = idx;
			result.outer_src_ip = cfg.balancer_ip;
			result.outer_dst_ip = bip;
			result.outer_total_len = ent_s[Stages-1].encap_len;
			result.outer_checksum = hdr_checksum(ent_s[Stages-1].encap_len,
				cfg.balancer_ip, bip);
			result.length_wrapped = ent_s[Stages-1].wrapped;
		end
	end

endmodule

// ===== rtl/ipip_dsr_backend_select_encap_top.sv =====
// ----------------------------------------------------------------------------
// IPIP DSR backend selector top level
// Classifies TCP service traffic, picks a backend by flow hash and builds the
// outer IPIP header fields.
// ----------------------------------------------------------------------------
// Channel   Handshake            Word
// in        in_valid/in_stall    in_data  (ipdsr_pkg::in_item_t)
// out       out_valid/out_stall  out_data (ipdsr_pkg::out_item_t)
// cfg       APB psel/penable     paddr, pwdata, prdata
//
// One word is taken per cycle while in_stall is low, one result leaves per
// cycle while out_stall is low; the rate is set by the five hash stages, each
// a single multiply by the FNV prime. Reset empties the queue and the pipeline
// and loads the register defaults. A stalled output holds the hash pipeline;
// the four-entry queue keeps taking words until it is full, and only then is
// in_stall raised.
// ----------------------------------------------------------------------------
`include "ipip_dsr_backend_select_encap_top_macros.svh"

module ipip_dsr_backend_select_encap_top #(
	parameter int BACKEND_COUNT = ipdsr_pkg::BACKEND_COUNT,
	parameter int QUEUE_DEPTH = ipdsr_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  ipdsr_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output ipdsr_pkg::out_item_t out_data,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ipdsr_pkg::PADDR_WIDTH-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	ipdsr_pkg::cfg_t cfg;
	ipdsr_pkg::q_status_t q_status;
	ipdsr_pkg::entry_t wr_entry;
	ipdsr_pkg::entry_t rd_entry;
	logic push;
	logic pop;

	ipdsr_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	ipdsr_front u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.service_port(cfg.service_port),
		.q_status(q_status),
		.push(push),
		.entry(wr_entry)
	);

	ipdsr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_entry(wr_entry),
		.pop(pop),
		.rd_entry(rd_entry),
		.status(q_status)
	);

	ipdsr_back #(
		.BACKEND_COUNT(BACKEND_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_status(q_status),
		.q_entry(rd_entry),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	`IPDSR_ASSERT_NEXT(a_accept_fills_queue, clk, arst_n, in_valid && !in_stall, !q_status.empty, "accepted word did not reach the queue")
	`IPDSR_ASSERT_SAME(a_src_is_balancer, clk, arst_n, out_valid && out_data.forward, out_data.outer_src_ip == cfg.balancer_ip, "outer source differs from balancer address")
	`IPDSR_ASSERT_SAME(a_pass_is_clear, clk, arst_n, out_valid && !out_data.forward, out_data.outer_dst_ip == 32'd0 && out_data.outer_checksum == 16'd0 && !out_data.length_wrapped, "passed word carries header values")
	`IPDSR_ASSERT_SAME(a_wrap_len_small, clk, arst_n, out_valid && out_data.length_wrapped, out_data.outer_total_len < ipdsr_pkg::OUTER_HDR_LEN, "wrapped length out of range")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// IPIP DSR backend selector testbench
// Drives parsed header words into the selector and checks every result word
// against a flow-hash and outer-header predictor. Registers are set through
// the APB port between phases, and both channels idle and stall at random,
// with one long output hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ipdsr_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 250;

	class encap_scoreboard;
		out_item_t expected_q[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function logic [31:0] swap32(logic [31:0] v);
			return {v[7:0], v[15:8], v[23:16], v[31:24]};
		endfunction

		function logic [15:0] swap16(logic [15:0] v);
			return {v[7:0], v[15:8]};
		endfunction

		function out_item_t predict_encap(in_item_t h, cfg_t c);
			out_item_t r;
			logic [31:0] words [5];
			logic [31:0] hash;
			logic [31:0] csum;
			logic [16:0] len_sum;
			r = '0;
			if (h.headers_complete !== 1'b1 || h.ether_type != ETH_IPV4 ||
					h.ip_proto != PROTO_TCP)
				return r;
			if (h.tcp_sport != c.service_port && h.tcp_dport != c.service_port)
				return r;
			words[0] = swap32(h.src_ip);
			words[1] = swap32(h.dst_ip);
			words[2] = {16'h0000, swap16(h.tcp_sport)};
			words[3] = {16'h0000, swap16(h.tcp_dport)};
			words[4] = {24'h000000, PROTO_TCP};
			hash = FNV_OFFSET;
			for (int k = 0; k < 5; k++)
				hash = (hash ^ words[k]) * FNV_PRIME;
			r.forward = 1'b1;
			r.backend_index = 1'(hash % 32'(BACKEND_COUNT));
			r.outer_src_ip = c.balancer_ip;
			r.outer_dst_ip = r.backend_index ? c.backend_ip_1 : c.backend_ip_0;
			len_sum = {1'b0, h.ip_total_len} + {1'b0, OUTER_HDR_LEN};
			r.outer_total_len = len_sum[15:0];
			r.length_wrapped = len_sum[16];
			csum = {16'h0000, OUTER_VER_IHL} + {16'h0000, r.outer_total_len} +
				{16'h0000, OUTER_TTL, PROTO_IPIP} +
				{16'h0000, r.outer_src_ip[31:16]} + {16'h0000, r.outer_src_ip[15:0]} +
				{16'h0000, r.outer_dst_ip[31:16]} + {16'h0000, r.outer_dst_ip[15:0]};
			csum = {16'h0000, csum[15:0]} + {16'h0000, csum[31:16]};
			csum = {16'h0000, csum[15:0]} + {16'h0000, csum[31:16]};
			r.outer_checksum = ~csum[15:0];
			return r;
		endfunction

		function void note_header(in_item_t h, cfg_t c);
			expected_q.push_back(predict_encap(h, c));
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				$error("result word with no header word waiting");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			check_field("forward", 32'(want.forward), 32'(got.forward));
			check_field("backend_index", 32'(want.backend_index), 32'(got.backend_index));
			check_field("outer_src_ip", want.outer_src_ip, got.outer_src_ip);
			check_field("outer_dst_ip", want.outer_dst_ip, got.outer_dst_ip);
			check_field("outer_total_len", 32'(want.outer_total_len),
				32'(got.outer_total_len));
			check_field("outer_checksum", 32'(want.outer_checksum), 32'(got.outer_checksum));
			check_field("length_wrapped", 32'(want.length_wrapped), 32'(got.length_wrapped));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_WIDTH-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	encap_scoreboard sb;
	cfg_t shadow_cfg;
	bit no_gaps;
	int stall_pct;
	bit hold_request;

	ipip_dsr_backend_select_encap_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("tb NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	initial begin
		int len;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 4);
				out_stall <= ($urandom_range(0, 99) < stall_pct);
				repeat (len) @(posedge clk);
			end
		end
	end

	function int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 0;
		if (r < 9)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_header(input in_item_t h);
		int gap;
		in_valid <= 1'b1;
		in_data <= h;
		do @(posedge clk); while (in_stall);
		sb.note_header(h, shadow_cfg);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_BACKEND_IP_0: shadow_cfg.backend_ip_0 = value;
			REG_BACKEND_IP_1: shadow_cfg.backend_ip_1 = value;
			REG_BALANCER_IP: shadow_cfg.balancer_ip = value;
			REG_SERVICE_PORT: shadow_cfg.service_port = value[15:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [31:0] b0, input logic [31:0] b1,
			input logic [31:0] lb, input logic [15:0] port);
		apb_write(REG_BACKEND_IP_0, b0);
		apb_write(REG_BACKEND_IP_1, b1);
		apb_write(REG_BALANCER_IP, lb);
		apb_write(REG_SERVICE_PORT, ($urandom & 32'hffff0000) | {16'h0000, port});
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function in_item_t make_header(logic complete, logic [15:0] etype, logic [7:0] proto,
			logic [31:0] sip, logic [31:0] dip, logic [15:0] sp, logic [15:0] dp,
			logic [15:0] len);
		in_item_t h;
		h.headers_complete = complete;
		h.ether_type = etype;
		h.ip_proto = proto;
		h.src_ip = sip;
		h.dst_ip = dip;
		h.tcp_sport = sp;
		h.tcp_dport = dp;
		h.ip_total_len = len;
		return h;
	endfunction

	function in_item_t random_header(logic [15:0] port);
		in_item_t h;
		int kind;
		h = make_header(1'b1, ETH_IPV4, PROTO_TCP, $urandom, $urandom, 16'($urandom),
			16'($urandom), 16'($urandom));
		if ($urandom_range(0, 7) == 0)
			h.ip_total_len = 16'($urandom_range(65500, 65535));
		kind = $urandom_range(0, 9);
		if (kind <= 8) begin
			case ($urandom_range(0, 2))
				0: h.tcp_sport = port;
				1: h.tcp_dport = port;
				default: begin
					h.tcp_sport = port;
					h.tcp_dport = port;
				end
			endcase
		end
		if (kind == 7) begin
			h.tcp_sport = 16'($urandom);
			h.tcp_dport = 16'($urandom);
		end else if (kind == 8) begin
			case ($urandom_range(0, 2))
				0: h.headers_complete = 1'b0;
				1: h.ether_type = 16'($urandom);
				default: h.ip_proto = 8'($urandom);
			endcase
		end else if (kind == 9) begin
			h.headers_complete = 1'($urandom);
			h.ether_type = 16'($urandom);
			h.ip_proto = 8'($urandom);
		end
		return h;
	endfunction

	initial begin
		logic [15:0] sp;
		sb = new();
		shadow_cfg = '0;
		shadow_cfg.service_port = DEFAULT_SERVICE_PORT;
		no_gaps = 1'b0;
		stall_pct = 25;
		hold_request = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		sp = DEFAULT_SERVICE_PORT;
		send_header(make_header(1, ETH_IPV4, PROTO_TCP, 32'h0a000001, 32'hc0a80001,
			16'd12345, sp, 16'd100));
		send_header(make_header(1, ETH_IPV4, PROTO_TCP, 32'h0a000002, 32'hc0a80001,
			sp, 16'd443, 16'd60));
		send_header(make_header(1, ETH_IPV4, PROTO_TCP, 32'h01020304, 32'h05060708,
			sp, sp, 16'd40));
		send_header(make_header(1, ETH_IPV4, PROTO_TCP, 32'h01020304, 32'h05060708,
			sp + 16'd1, sp - 16'd1, 16'd40));
		send_header(make_header(0, ETH_IPV4, PROTO_TCP, 32'h0a000001, 32'hc0a80001,
			16'd1000, sp, 16'd80));
		send_header(make_header(1, 16'h0801, PROTO_TCP, 32'h0a000001, 32'hc0a80001,
			16'd1000, sp, 16'd80));
		send_header(make_header(1, 16'h0000, PROTO_TCP, 32'h0a000001, 32'hc0a80001,
			16'd1000, sp, 16'd80));
		send_header(make_header(1, 16'hffff, PROTO_TCP, 32'h0a000001, 32'hc0a80001,
			16'd1000, sp, 16'd80));
		send_header(make_header(1, ETH_IPV4, 8'd17, 32'h0a000001, 32'hc0a80001,
			16'd1000, sp, 16'd80));
		send_header(make_header(1, ETH_IPV4, 8'd0, 32'h0a000001, 32'hc0a80001,
			16'd1000, sp, 16'd80));
		send_header(make_header(1, ETH_IPV4, 8'd255, 32'h0a000001, 32'hc0a80001,
			16'd1000, sp, 16'd80));
		send_header(make_header(1, ETH_IPV4, PROTO_TCP, 32'h0a000003, 32'hc0a80002,
			16'd2000, sp, 16'd0));
		send_header(make_header(1, ETH_IPV4, PROTO_TCP, 32'h0a000004, 32'hc0a80002,
			16'd2001, sp, 16'd65515));
		send_header(make_header(1, ETH_IPV4, PROTO_TCP, 32'h0a000005, 32'hc0a80002,
			16'd2002, sp, 16'd65516));
		send_header(make_header(1, ETH_IPV4, PROTO_TCP, 32'h0a000006, 32'hc0a80002,
			16'd2003, sp, 16'd65535));
		send_header(make_header(1, ETH_IPV4, PROTO_TCP, 32'h00000000, 32'h00000000,
			16'h0000, sp, 16'd52));
		send_header(make_header(1, ETH_IPV4, PROTO_TCP, 32'hffffffff, 32'hffffffff,
			16'hffff, sp, 16'hffff));
		send_header(make_header(1, ETH_IPV4, PROTO_TCP, 32'hffffffff, 32'h00000000,
			sp, 16'hffff, 16'h8000));
		wait_drained();

		for (int phase = 1; phase <= 6; phase++) begin
			case (phase)
				1: begin
					configure($urandom, $urandom, $urandom, 16'($urandom));
					no_gaps = 1'b0;
					stall_pct = 30;
				end
				2: begin
					configure(32'h00000000, 32'h00000000, 32'h00000000, 16'h0000);
					stall_pct = 60;
				end
				3: begin
					configure(32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff);
					stall_pct = 10;
				end
				4: begin
					configure($urandom, $urandom, $urandom, DEFAULT_SERVICE_PORT);
					no_gaps = 1'b1;
					stall_pct = 0;
				end
				5: begin
					configure($urandom, $urandom, $urandom, 16'd80);
					hold_request = 1'b1;
				end
				default: begin
					configure($urandom, $urandom, $urandom, 16'($urandom));
					no_gaps = 1'b0;
					stall_pct = 40;
				end
			endcase
			repeat (ITEMS_PER_PHASE)
				send_header(random_header(shadow_cfg.service_port));
			wait_drained();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule

// ===== ipip_dsr_backend_select_encap_top.f =====
+incdir+rtl
rtl/ipdsr_pkg.sv
rtl/ipdsr_cfg.sv
rtl/ipdsr_front.sv
rtl/ipdsr_queue.sv
rtl/ipdsr_back.sv
rtl/ipip_dsr_backend_select_encap_top.sv
tb/tb.sv
